// ----- rtl/bsr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsr_pkg
// Widths, constants and shared pipeline types of the slide/roll predictor.
// ----------------------------------------------------------------------------
package bsr_pkg;

  // item field widths
  localparam int POS_W  = 24;
  localparam int VEL_W  = 16;
  localparam int TIME_W = 20;
  localparam int RF_W   = 16;

  // internal widths
  localparam int N_W    = TIME_W - 1;     // non-negative time
  localparam int MAG_W  = VEL_W;          // |vel|, holds 32768
  localparam int S_W    = 2 * VEL_W;      // vx^2 + vy^2
  localparam int SPD_W  = 24;             // sqrt(s * 2^16)
  localparam int AN_W   = RF_W + N_W;     // a * n
  localparam int LHS_W  = AN_W + 4;       // 15 * a * n
  localparam int ANN_W  = AN_W + N_W;     // a * n * n
  localparam int REM_W  = 31;             // 88 * spd - 15 * a * n, clamped
  localparam int NUM_W  = 63;             // rolling numerator
  localparam int SNUM_W = 48;             // sliding numerator
  localparam int D8_W   = 39;             // distance, 1/4096 cm
  localparam int DEN_W  = 41;             // 25804800 * a
  localparam int QD_W   = 40;             // distance divider quotient bits
  localparam int ON_W   = 2 * MAG_W + D8_W - VEL_W + 2; // 2*|v|*d8 + spd
  localparam int OD_W   = SPD_W + 1;      // 2 * spd
  localparam int OQ_W   = 32;             // axis offset magnitude

  localparam logic [RF_W-1:0]  RF_RESET = 16'd1280;
  localparam logic [DEN_W-1:0] DEN_K    = 41'd25804800;
  localparam logic [15:0]      BIG_K    = 16'd54720;
  localparam logic [REM_W-1:0] ROLL_K   = 31'd88;
  localparam int               SLIDE_SH = 14;
  localparam logic signed [POS_W-1:0] POS_MAX = 24'sh7FFFFF;
  localparam logic signed [POS_W-1:0] POS_MIN = 24'sh800000;

  // per-item context carried down the whole pipe
  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [VEL_W-1:0] vel_x;
    logic signed [VEL_W-1:0] vel_y;
    logic                    terr;
    logic                    zero;
  } ctx_t;

  // time-dependent terms computed alongside the square root
  typedef struct packed {
    logic [N_W-1:0]   n;
    logic [LHS_W-1:0] lhs;
    logic [ANN_W-1:0] ann;
  } kin_t;

  // data riding beside the distance divider
  typedef struct packed {
    logic              slide;
    logic [D8_W-1:0]   d8s;
    logic [SPD_W-1:0]  spd;
    ctx_t              ctx;
  } qside_t;

endpackage

// ----- rtl/bsr_sqrt.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsr_sqrt
// Pipelined integer square root of (vx^2 + vy^2) * 2^16, one root bit a stage.
// ----------------------------------------------------------------------------
module bsr_sqrt (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         adv_i,
  input  logic                         valid_i,
  input  logic [bsr_pkg::S_W-1:0]      sum_i,
  input  bsr_pkg::kin_t                kin_i,
  input  bsr_pkg::ctx_t                ctx_i,
  output logic                         valid_o,
  output logic [bsr_pkg::SPD_W-1:0]    spd_o,
  output bsr_pkg::kin_t                kin_o,
  output bsr_pkg::ctx_t                ctx_o
);
  import bsr_pkg::*;

  localparam int RW = 2 * SPD_W + 1;

  logic [RW-1:0]    rem_q  [SPD_W];
  logic [SPD_W-1:0] root_q [SPD_W];
  logic             v_q    [SPD_W];
  kin_t             kin_q  [SPD_W];
  ctx_t             ctx_q  [SPD_W];

  for (genvar k = 0; k < SPD_W; k++) begin : g_step
    localparam int B = SPD_W - 1 - k;
    logic [RW-1:0]    rem_in;
    logic [RW-1:0]    trial;
    logic [SPD_W-1:0] root_in;
    logic             v_in;
    kin_t             kin_in;
    ctx_t             ctx_in;

    if (k == 0) begin : g_head
      assign rem_in  = {1'b0, sum_i, {(2 * SPD_W - S_W){1'b0}}};
      assign root_in = '0;
      assign v_in    = valid_i;
      assign kin_in  = kin_i;
      assign ctx_in  = ctx_i;
    end else begin : g_body
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign v_in    = v_q[k-1];
      assign kin_in  = kin_q[k-1];
      assign ctx_in  = ctx_q[k-1];
    end

    // (r + 2^B)^2 - r^2
    assign trial = (RW'(root_in) << (B + 1)) | (RW'(1) << (2 * B));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (adv_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        kin_q[k] <= kin_in;
        ctx_q[k] <= ctx_in;
        if (rem_in >= trial) begin
          rem_q[k]  <= rem_in - trial;
          root_q[k] <= root_in | (SPD_W'(1) << B);
        end else begin
          rem_q[k]  <= rem_in;
          root_q[k] <= root_in;
        end
      end
    end
  end

  assign valid_o = v_q[SPD_W-1];
  assign spd_o   = root_q[SPD_W-1];
  assign kin_o   = kin_q[SPD_W-1];
  assign ctx_o   = ctx_q[SPD_W-1];

endmodule

// ----- rtl/bsr_phase.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsr_phase
// Slide/roll decision, sliding distance and rolling numerator (four stages).
// ----------------------------------------------------------------------------
module bsr_phase (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         adv_i,
  input  logic                         valid_i,
  input  logic [bsr_pkg::SPD_W-1:0]    spd_i,
  input  bsr_pkg::kin_t                kin_i,
  input  bsr_pkg::ctx_t                ctx_i,
  output logic                         valid_o,
  output logic [bsr_pkg::NUM_W-1:0]    num_o,
  output bsr_pkg::qside_t              side_o
);
  import bsr_pkg::*;

  localparam int SPDN_W = SPD_W + N_W;
  localparam int SPD2_W = 2 * SPD_W;
  localparam int CMP_W  = LHS_W + 3;
  localparam int SFULL_W = ANN_W + 5;

  logic [3:0] v_q;

  // stage 1
  logic [SPDN_W-1:0] p1_spdn_q;
  logic [SPD2_W-1:0] p1_spd2_q;
  logic [REM_W-1:0]  p1_rem_q;
  logic [ANN_W-1:0]  p1_ann_q;
  logic              p1_slide_q;
  logic [SPD_W-1:0]  p1_spd_q;
  ctx_t              p1_ctx_q;
  // stage 2
  logic [NUM_W-1:0]    p2_big_q;
  logic [2*REM_W-1:0]  p2_rem2_q;
  logic [SNUM_W-1:0]   p2_snum_q;
  logic                p2_slide_q;
  logic [SPD_W-1:0]    p2_spd_q;
  ctx_t                p2_ctx_q;
  // stage 3
  logic [NUM_W+1:0]    p3_sub_q;
  logic [NUM_W-1:0]    p3_big_q;
  qside_t              p3_side_q;
  // stage 4
  logic [NUM_W-1:0]    p4_num_q;
  qside_t              p4_side_q;

  logic [CMP_W-1:0]   lhs7;
  logic [CMP_W-1:0]   spd16;
  logic [LHS_W-1:0]   r88;
  logic [SFULL_W-1:0] snum_full;
  logic [SNUM_W:0]    snum_rnd;
  logic [NUM_W+1:0]   big_ext;

  always_comb begin
    lhs7      = (CMP_W'(kin_i.lhs) << 3) - CMP_W'(kin_i.lhs);
    spd16     = CMP_W'(spd_i) << 4;
    r88       = LHS_W'(REM_W'(spd_i) * ROLL_K);
    snum_full = (SFULL_W'(p1_spdn_q) << 4) - (SFULL_W'(p1_ann_q) << 4)
              + SFULL_W'(p1_ann_q);
    snum_rnd  = (SNUM_W + 1)'(p2_snum_q) + ((SNUM_W + 1)'(1) << (SLIDE_SH - 1));
    big_ext   = (NUM_W + 2)'(p3_big_q);
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv_i) begin
      v_q <= {v_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      // stage 1: products of speed, clamped rolling remainder, phase test
      p1_spdn_q  <= SPDN_W'(spd_i) * SPDN_W'(kin_i.n);
      p1_spd2_q  <= SPD2_W'(spd_i) * SPD2_W'(spd_i);
      p1_rem_q   <= (kin_i.lhs > r88) ? '0 : REM_W'(r88 - kin_i.lhs);
      p1_ann_q   <= kin_i.ann;
      p1_slide_q <= lhs7 < spd16;
      p1_spd_q   <= spd_i;
      p1_ctx_q   <= ctx_i;
      // stage 2: squares and sliding numerator
      p2_big_q   <= NUM_W'(NUM_W'(p1_spd2_q) * NUM_W'(BIG_K));
      p2_rem2_q  <= (2 * REM_W)'(p1_rem_q) * (2 * REM_W)'(p1_rem_q);
      p2_snum_q  <= snum_full[SNUM_W-1:0];
      p2_slide_q <= p1_slide_q;
      p2_spd_q   <= p1_spd_q;
      p2_ctx_q   <= p1_ctx_q;
      // stage 3: 7 * rem^2 and rounded sliding distance
      p3_sub_q   <= ((NUM_W + 2)'(p2_rem2_q) << 3) - (NUM_W + 2)'(p2_rem2_q);
      p3_big_q   <= p2_big_q;
      p3_side_q.slide <= p2_slide_q;
      p3_side_q.d8s   <= D8_W'(snum_rnd >> SLIDE_SH);
      p3_side_q.spd   <= p2_spd_q;
      p3_side_q.ctx   <= p2_ctx_q;
      // stage 4: rolling numerator, floored at zero
      p4_num_q   <= (big_ext > p3_sub_q) ? NUM_W'(big_ext - p3_sub_q) : '0;
      p4_side_q  <= p3_side_q;
    end
  end

  assign valid_o = v_q[3];
  assign num_o   = p4_num_q;
  assign side_o  = p4_side_q;

endmodule

// ----- rtl/bsr_qdiv.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsr_qdiv
// Rolling distance: round(num / den), restoring division, one bit a stage.
// ----------------------------------------------------------------------------
module bsr_qdiv (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         adv_i,
  input  logic                         valid_i,
  input  logic [bsr_pkg::NUM_W-1:0]    num_i,
  input  logic [bsr_pkg::DEN_W-1:0]    den_i,
  input  bsr_pkg::qside_t              side_i,
  output logic                         valid_o,
  output logic [bsr_pkg::D8_W-1:0]     q_o,
  output bsr_pkg::qside_t              side_o
);
  import bsr_pkg::*;

  localparam int DW = DEN_W + 1;
  localparam int NW = NUM_W + 2;
  localparam int QW = QD_W;

  logic [DW-1:0] dv;
  logic [NW-1:0] nfull;

  // (2 num + den) / (2 den) gives the round-half-up quotient
  assign dv    = {den_i, 1'b0};
  assign nfull = NW'({num_i, 1'b0}) + NW'(den_i);

  logic [DW-1:0] rem_q  [QW];
  logic [QW-1:0] qn_q   [QW];
  logic          v_q    [QW];
  qside_t        side_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [DW-1:0] rem_in;
    logic [QW-1:0] qn_in;
    logic          v_in;
    qside_t        side_in;
    logic [DW:0]   t;
    logic          ge;

    if (k == 0) begin : g_head
      assign rem_in  = DW'(nfull >> QW);
      assign qn_in   = nfull[QW-1:0];
      assign v_in    = valid_i;
      assign side_in = side_i;
    end else begin : g_body
      assign rem_in  = rem_q[k-1];
      assign qn_in   = qn_q[k-1];
      assign v_in    = v_q[k-1];
      assign side_in = side_q[k-1];
    end

    assign t  = {rem_in, qn_in[QW-1]};
    assign ge = t >= {1'b0, dv};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (adv_i) begin
        v_q[k] <= v_in;
      end
    end

    // numerator bits shift out the top, quotient bits in at the bottom
    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        rem_q[k]  <= ge ? DW'(t - {1'b0, dv}) : DW'(t);
        qn_q[k]   <= {qn_in[QW-2:0], ge};
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = v_q[QW-1];
  assign q_o     = qn_q[QW-1][D8_W-1:0];
  assign side_o  = side_q[QW-1];

endmodule

// ----- rtl/bsr_odiv.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsr_odiv
// Per-axis offset magnitude round(|v| * d8 / spd), two lanes, one bit a stage.
// ----------------------------------------------------------------------------
module bsr_odiv (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         adv_i,
  input  logic                         valid_i,
  input  logic [bsr_pkg::D8_W-1:0]     d8_i,
  input  logic [bsr_pkg::SPD_W-1:0]    spd_i,
  input  bsr_pkg::ctx_t                ctx_i,
  output logic                         valid_o,
  output logic [bsr_pkg::OQ_W-1:0]     mag_x_o,
  output logic [bsr_pkg::OQ_W-1:0]     mag_y_o,
  output bsr_pkg::ctx_t                ctx_o
);
  import bsr_pkg::*;

  localparam int QW = OQ_W;

  logic [MAG_W-1:0] ax;
  logic [MAG_W-1:0] ay;

  assign ax = ctx_i.vel_x[VEL_W-1] ? MAG_W'(-ctx_i.vel_x) : MAG_W'(ctx_i.vel_x);
  assign ay = ctx_i.vel_y[VEL_W-1] ? MAG_W'(-ctx_i.vel_y) : MAG_W'(ctx_i.vel_y);

  // head stage: numerators 2|v|d8 + spd and divisor 2 spd
  logic             h_v_q;
  logic [ON_W-1:0]  h_nx_q;
  logic [ON_W-1:0]  h_ny_q;
  logic [OD_W-1:0]  h_d_q;
  ctx_t             h_ctx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_v_q <= 1'b0;
    end else if (adv_i) begin
      h_v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      h_nx_q  <= ((ON_W'(ax) * ON_W'(d8_i)) << 1) + ON_W'(spd_i);
      h_ny_q  <= ((ON_W'(ay) * ON_W'(d8_i)) << 1) + ON_W'(spd_i);
      h_d_q   <= {spd_i, 1'b0};
      h_ctx_q <= ctx_i;
    end
  end

  logic [OD_W-1:0] rx_q  [QW];
  logic [OD_W-1:0] ry_q  [QW];
  logic [QW-1:0]   qx_q  [QW];
  logic [QW-1:0]   qy_q  [QW];
  logic [OD_W-1:0] d_q   [QW];
  logic            v_q   [QW];
  ctx_t            ctx_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [OD_W-1:0] rx_in;
    logic [OD_W-1:0] ry_in;
    logic [QW-1:0]   qx_in;
    logic [QW-1:0]   qy_in;
    logic [OD_W-1:0] d_in;
    logic            v_in;
    ctx_t            ctx_in;
    logic [OD_W:0]   tx;
    logic [OD_W:0]   ty;
    logic            gx;
    logic            gy;

    if (k == 0) begin : g_head
      assign rx_in  = OD_W'(h_nx_q >> QW);
      assign ry_in  = OD_W'(h_ny_q >> QW);
      assign qx_in  = h_nx_q[QW-1:0];
      assign qy_in  = h_ny_q[QW-1:0];
      assign d_in   = h_d_q;
      assign v_in   = h_v_q;
      assign ctx_in = h_ctx_q;
    end else begin : g_body
      assign rx_in  = rx_q[k-1];
      assign ry_in  = ry_q[k-1];
      assign qx_in  = qx_q[k-1];
      assign qy_in  = qy_q[k-1];
      assign d_in   = d_q[k-1];
      assign v_in   = v_q[k-1];
      assign ctx_in = ctx_q[k-1];
    end

    assign tx = {rx_in, qx_in[QW-1]};
    assign ty = {ry_in, qy_in[QW-1]};
    assign gx = tx >= {1'b0, d_in};
    assign gy = ty >= {1'b0, d_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (adv_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        rx_q[k]  <= gx ? OD_W'(tx - {1'b0, d_in}) : OD_W'(tx);
        ry_q[k]  <= gy ? OD_W'(ty - {1'b0, d_in}) : OD_W'(ty);
        qx_q[k]  <= {qx_in[QW-2:0], gx};
        qy_q[k]  <= {qy_in[QW-2:0], gy};
        d_q[k]   <= d_in;
        ctx_q[k] <= ctx_in;
      end
    end
  end

  assign valid_o = v_q[QW-1];
  assign mag_x_o = qx_q[QW-1];
  assign mag_y_o = qy_q[QW-1];
  assign ctx_o   = ctx_q[QW-1];

endmodule

// ----- rtl/ball_slide_roll_position_predictor.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ball_slide_roll_position_predictor
// Predicts a ball position after a slide phase and a roll phase to rest.
//
//   channel | signals                                        | direction
//   --------+------------------------------------------------+----------
//   config  | cfg_we_i, cfg_wdata_i (friction term)          | in
//   input   | in_valid_i / in_stall_o, pos, vel, elapsed time| in
//   output  | out_valid_o / out_stall_i, pred_x/y, time_error| out
//
// One item enters every cycle while the output is not stalled; 105 register
// stages: 3 input stages, the 24-stage square root, 4 phase stages, the
// 40-stage distance divider, the 33-stage axis divider and the output register.
// Reset clears all valid bits and loads the friction term with 1280.
// A stalled output item holds the whole pipe in place; nothing is dropped.
// ----------------------------------------------------------------------------
module ball_slide_roll_position_predictor (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [bsr_pkg::RF_W-1:0]            cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [bsr_pkg::POS_W-1:0]    pos_x_i,
  input  logic signed [bsr_pkg::POS_W-1:0]    pos_y_i,
  input  logic signed [bsr_pkg::VEL_W-1:0]    vel_x_i,
  input  logic signed [bsr_pkg::VEL_W-1:0]    vel_y_i,
  input  logic signed [bsr_pkg::TIME_W-1:0]   elapsed_time_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [bsr_pkg::POS_W-1:0]    pred_x_o,
  output logic signed [bsr_pkg::POS_W-1:0]    pred_y_o,
  output logic                                time_error_o
);
  import bsr_pkg::*;

  localparam int SUM_W = POS_W + 10;

  // roll friction register and derived divisor
  logic [RF_W-1:0]  rf_q;
  logic [RF_W-1:0]  a_eff;
  logic [DEN_W-1:0] den_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rf_q <= RF_RESET;
    end else if (cfg_we_i) begin
      rf_q <= cfg_wdata_i;
    end
  end

  assign a_eff = (rf_q == '0) ? RF_W'(1) : rf_q;

  always_ff @(posedge clk_i) begin
    den_q <= DEN_W'(a_eff) * DEN_K;
  end

  // global advance: hold everything while the output item is stalled
  logic adv;
  logic out_v_q;

  assign adv        = !(out_v_q && out_stall_i);
  assign in_stall_o = !adv;

  // stage 0: input register
  logic                     s0_v_q;
  logic signed [POS_W-1:0]  s0_px_q, s0_py_q;
  logic signed [VEL_W-1:0]  s0_vx_q, s0_vy_q;
  logic signed [TIME_W-1:0] s0_t_q;

  // stage 1: squares and a * n
  logic             s1_v_q;
  logic [S_W-1:0]   s1_ax2_q, s1_ay2_q;
  logic [AN_W-1:0]  s1_an_q;
  logic [N_W-1:0]   s1_n_q;
  ctx_t             s1_ctx_q;

  // stage 2: speed squared, 15an, a n^2
  logic             s2_v_q;
  logic [S_W-1:0]   s2_sum_q;
  kin_t             s2_kin_q;
  ctx_t             s2_ctx_q;
  ctx_t             s2_ctx_d;

  logic [MAG_W-1:0] ax, ay;
  logic [S_W-1:0]   sum1;

  assign ax   = s0_vx_q[VEL_W-1] ? MAG_W'(-s0_vx_q) : MAG_W'(s0_vx_q);
  assign ay   = s0_vy_q[VEL_W-1] ? MAG_W'(-s0_vy_q) : MAG_W'(s0_vy_q);
  assign sum1 = s1_ax2_q + s1_ay2_q;

  // zero-speed flag joins the context here
  always_comb begin
    s2_ctx_d      = s1_ctx_q;
    s2_ctx_d.zero = (sum1 == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q <= 1'b0;
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else if (adv) begin
      s0_v_q <= in_valid_i;
      s1_v_q <= s0_v_q;
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s0_px_q <= pos_x_i;
      s0_py_q <= pos_y_i;
      s0_vx_q <= vel_x_i;
      s0_vy_q <= vel_y_i;
      s0_t_q  <= elapsed_time_i;

      s1_ax2_q       <= S_W'(ax) * S_W'(ax);
      s1_ay2_q       <= S_W'(ay) * S_W'(ay);
      s1_an_q        <= AN_W'(a_eff) * AN_W'(s0_t_q[N_W-1:0]);
      s1_n_q         <= s0_t_q[N_W-1:0];
      s1_ctx_q.pos_x <= s0_px_q;
      s1_ctx_q.pos_y <= s0_py_q;
      s1_ctx_q.vel_x <= s0_vx_q;
      s1_ctx_q.vel_y <= s0_vy_q;
      s1_ctx_q.terr  <= s0_t_q[TIME_W-1];
      s1_ctx_q.zero  <= 1'b0;

      s2_sum_q      <= sum1;
      s2_kin_q.n    <= s1_n_q;
      s2_kin_q.lhs  <= (LHS_W'(s1_an_q) << 4) - LHS_W'(s1_an_q);
      s2_kin_q.ann  <= ANN_W'(s1_an_q) * ANN_W'(s1_n_q);
      s2_ctx_q      <= s2_ctx_d;
    end
  end

  // speed
  logic             sq_v;
  logic [SPD_W-1:0] sq_spd;
  kin_t             sq_kin;
  ctx_t             sq_ctx;

  bsr_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (s2_v_q),
    .sum_i   (s2_sum_q),
    .kin_i   (s2_kin_q),
    .ctx_i   (s2_ctx_q),
    .valid_o (sq_v),
    .spd_o   (sq_spd),
    .kin_o   (sq_kin),
    .ctx_o   (sq_ctx)
  );

  // phase terms
  logic             ph_v;
  logic [NUM_W-1:0] ph_num;
  qside_t           ph_side;

  bsr_phase u_phase (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (sq_v),
    .spd_i   (sq_spd),
    .kin_i   (sq_kin),
    .ctx_i   (sq_ctx),
    .valid_o (ph_v),
    .num_o   (ph_num),
    .side_o  (ph_side)
  );

  // rolling distance
  logic            qd_v;
  logic [D8_W-1:0] qd_q;
  qside_t          qd_side;

  bsr_qdiv u_qdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (ph_v),
    .num_i   (ph_num),
    .den_i   (den_q),
    .side_i  (ph_side),
    .valid_o (qd_v),
    .q_o     (qd_q),
    .side_o  (qd_side)
  );

  // axis offsets
  logic            od_v;
  logic [OQ_W-1:0] od_mx, od_my;
  ctx_t            od_ctx;

  bsr_odiv u_odiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (qd_v),
    .d8_i    (qd_side.slide ? qd_side.d8s : qd_q),
    .spd_i   (qd_side.spd),
    .ctx_i   (qd_side.ctx),
    .valid_o (od_v),
    .mag_x_o (od_mx),
    .mag_y_o (od_my),
    .ctx_o   (od_ctx)
  );

  // apply signed offsets and saturate
  logic signed [SUM_W-1:0] ox, oy, sx, sy;
  logic signed [POS_W-1:0] px, py;

  always_comb begin
    ox = $signed(SUM_W'(od_mx));
    oy = $signed(SUM_W'(od_my));
    if (od_ctx.vel_x[VEL_W-1]) begin
      ox = -ox;
    end
    if (od_ctx.vel_y[VEL_W-1]) begin
      oy = -oy;
    end
    sx = SUM_W'(od_ctx.pos_x) + ox;
    sy = SUM_W'(od_ctx.pos_y) + oy;
    if (sx > SUM_W'(POS_MAX)) begin
      px = POS_MAX;
    end else if (sx < SUM_W'(POS_MIN)) begin
      px = POS_MIN;
    end else begin
      px = sx[POS_W-1:0];
    end
    if (sy > SUM_W'(POS_MAX)) begin
      py = POS_MAX;
    end else if (sy < SUM_W'(POS_MIN)) begin
      py = POS_MIN;
    end else begin
      py = sy[POS_W-1:0];
    end
  end

  // output register
  logic signed [POS_W-1:0] out_x_q, out_y_q;
  logic                    out_e_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv) begin
      out_v_q <= od_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (od_ctx.terr) begin
        out_x_q <= POS_MAX;
        out_y_q <= POS_MAX;
        out_e_q <= 1'b1;
      end else if (od_ctx.zero) begin
        out_x_q <= od_ctx.pos_x;
        out_y_q <= od_ctx.pos_y;
        out_e_q <= 1'b0;
      end else begin
        out_x_q <= px;
        out_y_q <= py;
        out_e_q <= 1'b0;
      end
    end
  end

  assign out_valid_o  = out_v_q;
  assign pred_x_o     = out_x_q;
  assign pred_y_o     = out_y_q;
  assign time_error_o = out_e_q;

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the slide/roll ball position predictor. Items are
// driven through the valid/stall input channel, and a bit-exact predictor
// computes each expected position when its item is accepted. A monitor pops
// the oldest expected position for every output item and compares the fields.
// The bench runs directed corner items, then random items, under several
// friction settings, with random idle cycles on both channels.
// ----------------------------------------------------------------------------
module tb_top;
  import bsr_pkg::*;

  typedef struct {
    logic signed [POS_W-1:0] px;
    logic signed [POS_W-1:0] py;
    logic                    terr;
  } pred_t;

  localparam int DRAIN_CYC = 130;   // pipe latency plus margin

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       cfg_we_i = 1'b0;
  logic [RF_W-1:0]            cfg_wdata_i = '0;
  logic                       in_valid_i = 1'b0;
  logic                       in_stall_o;
  logic signed [POS_W-1:0]    pos_x_i = '0;
  logic signed [POS_W-1:0]    pos_y_i = '0;
  logic signed [VEL_W-1:0]    vel_x_i = '0;
  logic signed [VEL_W-1:0]    vel_y_i = '0;
  logic signed [TIME_W-1:0]   elapsed_time_i = '0;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  logic signed [POS_W-1:0]    pred_x_o;
  logic signed [POS_W-1:0]    pred_y_o;
  logic                       time_error_o;

  pred_t           pos_queue[$];
  logic [RF_W-1:0] friction = RF_RESET;
  int              mismatches = 0;
  bit              no_idle = 1'b0;

  ball_slide_roll_position_predictor i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .pos_x_i        (pos_x_i),
    .pos_y_i        (pos_y_i),
    .vel_x_i        (vel_x_i),
    .vel_y_i        (vel_y_i),
    .elapsed_time_i (elapsed_time_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .pred_x_o       (pred_x_o),
    .pred_y_o       (pred_y_o),
    .time_error_o   (time_error_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // integer square root, bit by bit
  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // nearest offset along one axis, ties away from zero, then saturate
  function automatic logic signed [POS_W-1:0] move_axis(longint pos, longint vel,
      longint unsigned d8, longint unsigned spd);
    longint unsigned m;
    longint          r;
    m = (2 * longint'(vel < 0 ? -vel : vel) * d8 + spd) / (2 * spd);
    r = (vel < 0) ? pos - longint'(m) : pos + longint'(m);
    if (r > 8388607) r = 8388607;
    if (r < -8388608) r = -8388608;
    return r[POS_W-1:0];
  endfunction

  // predicted position of the ball after the slide and roll phases
  function automatic pred_t predict_position(logic signed [POS_W-1:0] px,
      logic signed [POS_W-1:0] py, logic signed [VEL_W-1:0] vx,
      logic signed [VEL_W-1:0] vy, logic signed [TIME_W-1:0] t,
      logic [RF_W-1:0] rf);
    pred_t           p;
    longint unsigned ax, ay, s, spd, a, n, d8, lhs, rhs, rem, big, sub, num, den, q;
    p.terr = 1'b0;
    if (t < 0) begin
      p.px = POS_MAX;
      p.py = POS_MAX;
      p.terr = 1'b1;
      return p;
    end
    ax = (vx < 0) ? -longint'(vx) : longint'(vx);
    ay = (vy < 0) ? -longint'(vy) : longint'(vy);
    s = ax * ax + ay * ay;
    if (s == 0) begin
      p.px = px;
      p.py = py;
      return p;
    end
    spd = int_sqrt(s << 16);
    a = (rf != 0) ? longint'(rf) : 1;
    n = longint'(t);
    if (105 * a * n < 16 * spd) begin
      // still sliding
      d8 = (16 * spd * n - 15 * a * n * n + 8192) >> 14;
    end else begin
      // rolling, or already at rest
      lhs = 15 * a * n;
      rhs = 88 * spd;
      rem = (lhs > rhs) ? 0 : rhs - lhs;
      big = 54720 * spd * spd;
      sub = 7 * rem * rem;
      num = (big > sub) ? big - sub : 0;
      den = 25804800 * a;
      q = num / den;
      if (2 * (num % den) >= den) q++;
      d8 = q;
    end
    p.px = move_axis(longint'(px), longint'(vx), d8, spd);
    p.py = move_axis(longint'(py), longint'(vy), d8, spd);
    return p;
  endfunction

  // random output stall, off during no-idle stretches
  always @(negedge clk_i) begin
    out_stall_i <= !no_idle && ($urandom_range(99) < 12);
  end

  // compare every accepted output item with the oldest expected position
  always @(posedge clk_i) begin
    pred_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pos_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected output item x=%0d y=%0d", pred_x_o, pred_y_o);
      end else begin
        e = pos_queue.pop_front();
        if (pred_x_o !== e.px || pred_y_o !== e.py || time_error_o !== e.terr) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp x=%0d y=%0d err=%0b, got x=%0d y=%0d err=%0b",
                     e.px, e.py, e.terr, pred_x_o, pred_y_o, time_error_o);
        end
      end
    end
  end

  // drive one item and hold it until accepted
  task automatic send_item(logic signed [POS_W-1:0] px, logic signed [POS_W-1:0] py,
      logic signed [VEL_W-1:0] vx, logic signed [VEL_W-1:0] vy,
      logic signed [TIME_W-1:0] t);
    if (!no_idle && $urandom_range(99) < 12) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    pos_x_i        <= px;
    pos_y_i        <= py;
    vel_x_i        <= vx;
    vel_y_i        <= vy;
    elapsed_time_i <= t;
    do @(posedge clk_i); while (in_stall_o);
    pos_queue.push_back(predict_position(px, py, vx, vy, t, friction));
    @(negedge clk_i);
  endtask

  // wait for the pipe to empty, then write the friction term
  task automatic set_friction(logic [RF_W-1:0] rf);
    in_valid_i <= 1'b0;
    while (pos_queue.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYC) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= rf;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    friction = rf;
  endtask

  task automatic test_directed();
    send_item(0, 0, 0, 0, 0);
    send_item(24'sh7FFFFF, 24'sh800000, 0, 0, 1000);          // zero speed
    send_item(100, -100, 500, -300, -1);                      // negative time
    send_item(0, 0, 1, 1, 20'sh80000);                        // most negative time
    send_item(0, 0, 16'sh7FFF, 16'sh7FFF, 20'sh7FFFF);
    send_item(0, 0, 16'sh8000, 16'sh8000, 20'sh7FFFF);
    send_item(0, 0, 16'sh8000, 0, 10);                        // early slide
    send_item(0, 0, 0, 16'sh7FFF, 300);
    send_item(24'sh7FFFFF, 24'sh7FFFFF, 16'sh7FFF, 16'sh7FFF, 5000);   // saturate high
    send_item(24'sh800000, 24'sh800000, 16'sh8000, 16'sh8000, 5000);   // saturate low
    send_item(1234, -5678, 3000, 4000, 0);                    // zero time
    send_item(0, 0, 3000, 4000, 50);
    send_item(0, 0, 3000, 4000, 200);                         // near slide end
    send_item(0, 0, 3000, 4000, 2000);                        // rolling
    send_item(0, 0, 3000, 4000, 100000);                      // at rest
    send_item(-1, -1, -1, 0, 1);
    send_item(0, 0, 1, -1, 20'sh7FFFF);
    send_item(24'sh555555, 24'shAAAAAA, 16'sh5555, 16'shAAAA, 20'sh55555);
    send_item(24'shAAAAAA, 24'sh555555, 16'shAAAA, 16'sh5555, 20'h2AAAA);
  endtask

  task automatic test_random(int count);
    logic signed [VEL_W-1:0]  vx, vy;
    logic signed [TIME_W-1:0] t;
    int                       k;
    for (int i = 0; i < count; i++) begin
      no_idle = (i >= count / 3) && (i < count / 3 + 80);
      k = $urandom_range(99);
      if (k < 40) begin
        vx = VEL_W'($urandom_range(2000) - 1000);
        vy = VEL_W'($urandom_range(2000) - 1000);
      end else begin
        vx = VEL_W'($urandom);
        vy = VEL_W'($urandom);
      end
      if (k % 20 == 0) begin
        vx = 0;
        vy = 0;
      end
      k = $urandom_range(99);
      if (k < 8) t = -$signed(20'($urandom_range(524288, 1)));
      else if (k < 45) t = TIME_W'($urandom_range(500));
      else if (k < 80) t = TIME_W'($urandom_range(20000));
      else t = TIME_W'($urandom_range(524287));
      if ($urandom_range(99) < 5) t = TIME_W'($urandom);
      send_item(POS_W'($urandom), POS_W'($urandom), vx, vy, t);
    end
    no_idle = 1'b0;
  endtask

  task automatic test_friction_sweep();
    set_friction(16'd1);
    test_directed();
    test_random(200);
    set_friction(16'hFFFF);
    test_directed();
    test_random(200);
    set_friction(16'($urandom_range(65535, 1)));
    test_random(200);
    set_friction(RF_RESET);
    test_random(300);
  endtask

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random(600);
    test_friction_sweep();
    in_valid_i <= 1'b0;
    while (pos_queue.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYC) @(negedge clk_i);
    if (mismatches == 0 && pos_queue.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/bsr_pkg.sv
rtl/bsr_sqrt.sv
rtl/bsr_phase.sv
rtl/bsr_qdiv.sv
rtl/bsr_odiv.sv
rtl/ball_slide_roll_position_predictor.sv
bench/tb_top.sv
